// ----- sv/kss_pkg.sv -----
`timescale 1ns / 1ps
package kss_pkg;

  localparam int STATE_SIZE     = 2;
  localparam int COEF_FRAC_BITS = 12;

  localparam int IDX_W     = 1;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Sum of two coefficient products, exact.
  localparam int KH_W  = 2 * COEF_W + 2;
  // Entry of A - K*H after the fraction shift.
  localparam int M_W   = KH_W - COEF_FRAC_BITS + 1;
  localparam int P_W   = M_W + DATA_W;
  localparam int ACC_W = P_W + 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_SIZE - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANSITION  = 3'd0,
    REG_CONTROL     = 3'd1,
    REG_GAIN        = 3'd2,
    REG_OBSERVATION = 3'd3,
    REG_INITIAL     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_KH = 2'd0,
    OP_BU = 2'd1,
    OP_KZ = 2'd2,
    OP_MX = 2'd3
  } op_kind_t;

  typedef logic [1:0][DATA_W-1:0] vec_t;

  typedef struct packed {
    logic             valid;
    op_kind_t         kind;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] k;
    logic             first;
    logic             last;
    logic             item_end;
  } kss_op_t;

  typedef struct packed {
    logic done;
    logic sat;
    vec_t est;
  } kss_res_t;

  // Coefficient (r,c) of a row-major packed 2x2 matrix.
  function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] m,
                                                    input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
    logic [5:0] off;
    off = {r, c, 4'b0000};
    return $signed(m[off +: COEF_W]);
  endfunction

endpackage

// ----- sv/kss_ifs.sv -----
`timescale 1ns / 1ps
interface kss_cfg_if import kss_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface kss_item_if import kss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     restart;
  logic signed [DATA_W-1:0] measurement_0;
  logic signed [DATA_W-1:0] measurement_1;
  logic signed [DATA_W-1:0] control_0;
  logic signed [DATA_W-1:0] control_1;
  modport source (output valid, restart, measurement_0, measurement_1, control_0, control_1,
                  input ready);
  modport sink (input valid, restart, measurement_0, measurement_1, control_0, control_1,
                output ready);
endinterface

interface kss_result_if import kss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] estimate_0;
  logic signed [DATA_W-1:0] estimate_1;
  logic                     saturated;
  modport source (output valid, estimate_0, estimate_1, saturated, input ready);
  modport sink (input valid, estimate_0, estimate_1, saturated, output ready);
endinterface

// ----- sv/kss_ctrl.sv -----
`timescale 1ns / 1ps
module kss_ctrl import kss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    done,
  output logic    busy,
  output kss_op_t op
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } ctrl_state_t;

  ctrl_state_t      state;
  op_kind_t         kind;
  logic [IDX_W-1:0] r;
  logic [IDX_W-1:0] c;
  logic [IDX_W-1:0] k;

  assign busy = (state != S_IDLE);

  always_comb begin
    op.valid    = (state == S_ISSUE);
    op.kind     = kind;
    op.r        = r;
    op.c        = c;
    op.k        = k;
    op.first    = (kind == OP_BU) && (c == '0);
    op.last     = (kind == OP_MX) && (c == LAST_IDX);
    op.item_end = (kind == OP_MX) && (c == LAST_IDX) && (r == LAST_IDX);
  end

  // Per matrix entry: the K*H products, then B*u, K*z and finally M*x.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind  <= OP_KH;
      r     <= '0;
      c     <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          kind <= OP_KH;
          r    <= '0;
          c    <= '0;
          k    <= '0;
          if (start) state <= S_ISSUE;
        end
        S_ISSUE: begin
          case (kind)
            OP_KH: begin
              if (k == LAST_IDX) kind <= OP_BU;
              else k <= k + 1'b1;
            end
            OP_BU: kind <= OP_KZ;
            OP_KZ: kind <= OP_MX;
            OP_MX: begin
              kind <= OP_KH;
              k    <= '0;
              if (c == LAST_IDX) begin
                c <= '0;
                if (r == LAST_IDX) state <= S_WAIT;
                else r <= r + 1'b1;
              end else begin
                c <= c + 1'b1;
              end
            end
            default: kind <= OP_KH;
          endcase
        end
        S_WAIT: begin
          if (done) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/kss_mac.sv -----
`timescale 1ns / 1ps
module kss_mac import kss_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  kss_op_t          op,
  input  logic [CFG_W-1:0] trans,
  input  logic [CFG_W-1:0] ctl,
  input  logic [CFG_W-1:0] gain,
  input  logic [CFG_W-1:0] obs,
  input  vec_t             x,
  input  vec_t             z,
  input  vec_t             u,
  output kss_res_t         res
);

  localparam logic signed [ACC_W-1:0] ACC_MAX =
    $signed({{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_MIN =
    $signed({{(ACC_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});

  logic signed [M_W-1:0]    a;
  logic signed [DATA_W-1:0] b;
  logic signed [P_W-1:0]    p;
  kss_op_t                  tag1;
  kss_op_t                  tag2;
  logic signed [KH_W-1:0]   kh;
  logic signed [M_W-1:0]    m_reg;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  term;
  logic [DATA_W-1:0]        nx [2];
  logic [DATA_W-1:0]        clip;
  logic                     clip_flag;
  logic                     sat;
  logic                     done;

  // Operand selection for the shared multiplier.
  always_comb begin
    a = '0;
    b = '0;
    case (op.kind)
      OP_KH: begin
        a = M_W'(coef(gain, op.r, op.k));
        b = DATA_W'(coef(obs, op.k, op.c));
      end
      OP_BU: begin
        a = M_W'(coef(ctl, op.r, op.c));
        b = $signed(u[op.c]);
      end
      OP_KZ: begin
        a = M_W'(coef(gain, op.r, op.c));
        b = $signed(z[op.c]);
      end
      OP_MX: begin
        a = m_reg;
        b = $signed(x[op.c]);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign term = ACC_W'(p >>> COEF_FRAC_BITS);

  always_comb begin
    clip      = acc[DATA_W-1:0];
    clip_flag = 1'b0;
    if (acc > ACC_MAX) begin
      clip      = ACC_MAX[DATA_W-1:0];
      clip_flag = 1'b1;
    end else if (acc < ACC_MIN) begin
      clip      = ACC_MIN[DATA_W-1:0];
      clip_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid <= 1'b0;
      tag2.valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      tag1.valid <= op.valid;
      tag2.valid <= tag1.valid;
      done       <= tag2.valid && tag2.last && tag2.item_end;
    end

    // Multiply stage.
    if (op.valid) begin
      p                    <= a * b;
      {tag1.kind, tag1.r, tag1.c, tag1.k} <= {op.kind, op.r, op.c, op.k};
      {tag1.first, tag1.last, tag1.item_end} <= {op.first, op.last, op.item_end};
    end

    // Accumulate stage. The M entry is formed once both K*H products are in.
    if (tag1.valid) begin
      case (tag1.kind)
        OP_KH: kh <= (tag1.k == '0) ? KH_W'(p) : kh + KH_W'(p);
        OP_BU: begin
          m_reg <= M_W'(coef(trans, tag1.r, tag1.c)) - M_W'(kh >>> COEF_FRAC_BITS);
          acc   <= (tag1.first ? '0 : acc) + term;
        end
        OP_KZ: acc <= acc + term;
        OP_MX: acc <= acc + term;
        default: acc <= acc;
      endcase
    end
    {tag2.kind, tag2.r, tag2.c, tag2.k} <= {tag1.kind, tag1.r, tag1.c, tag1.k};
    {tag2.first, tag2.last, tag2.item_end} <= {tag1.first, tag1.last, tag1.item_end};

    // Saturate a finished row.
    if (tag2.valid && tag2.last) begin
      nx[tag2.r] <= clip;
      sat        <= ((tag2.r == '0) ? 1'b0 : sat) | clip_flag;
    end
  end

  assign res.done   = done;
  assign res.sat    = sat;
  assign res.est[0] = nx[0];
  assign res.est[1] = nx[1];

endmodule

// ----- sv/steady_state_kalman_step_top.sv -----
`timescale 1ns / 1ps
// A restart transaction loads the initial estimate, which then moves on the pending flag into
// the result register; a filter step runs every product through the multiply, accumulate and
// saturate stages of the single shared multiplier, one step at a time.
// Reset (rst, synchronous, active high) clears all configuration registers, the estimate
// and the handshake state; the result register holds no transaction after reset.
module steady_state_kalman_step_top import kss_pkg::*; (
  input logic          clk,
  input logic          rst,
  kss_cfg_if.sink      cfg,
  kss_item_if.sink     item,
  kss_result_if.source result
);

  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  logic [CFG_W-1:0] trans;
  logic [CFG_W-1:0] ctl;
  logic [CFG_W-1:0] gain;
  logic [CFG_W-1:0] obs;
  logic [CFG_W-1:0] init;

  // Kept estimate and the inputs of the step in progress.
  vec_t x;
  vec_t z;
  vec_t u;

  // A finished estimate waiting to move into the result register.
  logic pend;
  logic pend_sat;

  logic                     out_valid;
  logic signed [DATA_W-1:0] out_est0;
  logic signed [DATA_W-1:0] out_est1;
  logic                     out_sat;

  logic     busy;
  logic     item_take;
  logic     start;
  logic     out_load;
  kss_op_t  op;
  kss_res_t res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans <= '0;
      ctl   <= '0;
      gain  <= '0;
      obs   <= '0;
      init  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TRANSITION:  trans <= cfg.data;
        REG_CONTROL:     ctl   <= cfg.data;
        REG_GAIN:        gain  <= cfg.data;
        REG_OBSERVATION: obs   <= cfg.data;
        REG_INITIAL:     init  <= cfg.data;
        default: ;
      endcase
    end
  end

  // One item at a time: a new transaction is taken only when nothing is being computed
  // and no finished estimate is waiting. A result still sitting in the output register
  // does not block acceptance.
  assign item.ready = !busy && !pend;
  assign item_take  = item.valid && item.ready;
  assign start      = item_take && !item.restart;
  assign out_load   = pend && (!out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (item_take) begin
      z[0] <= item.measurement_0;
      z[1] <= (STATE_SIZE >= 2) ? item.measurement_1 : '0;
      u[0] <= item.control_0;
      u[1] <= (STATE_SIZE >= 2) ? item.control_1 : '0;
    end
  end

  // The estimate changes on a restart or when the datapath finishes a step.
  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      pend     <= 1'b0;
      pend_sat <= 1'b0;
    end else begin
      if (item_take && item.restart) begin
        x[0]     <= init[DATA_W-1:0];
        x[1]     <= (STATE_SIZE >= 2) ? init[CFG_W-1:DATA_W] : '0;
        pend     <= 1'b1;
        pend_sat <= 1'b0;
      end else if (res.done) begin
        x[0]     <= res.est[0];
        x[1]     <= (STATE_SIZE >= 2) ? res.est[1] : '0;
        pend     <= 1'b1;
        pend_sat <= res.sat;
      end else if (out_load) begin
        pend <= 1'b0;
      end
    end
  end

  // Output register parting the compute side from the result consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_est0 <= $signed(x[0]);
      out_est1 <= $signed(x[1]);
      out_sat  <= pend_sat;
    end
  end

  assign result.valid      = out_valid;
  assign result.estimate_0 = out_est0;
  assign result.estimate_1 = out_est1;
  assign result.saturated  = out_sat;

  // Sequencer walks every product of every matrix entry through the shared multiplier.
  kss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .done  (res.done),
    .busy  (busy),
    .op    (op)
  );

  // Multiply, accumulate and saturate pipeline.
  kss_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .trans (trans),
    .ctl   (ctl),
    .gain  (gain),
    .obs   (obs),
    .x     (x),
    .z     (z),
    .u     (u),
    .res   (res)
  );

endmodule

// ----- sv/kss_checker.sv -----
`timescale 1ns / 1ps
module kss_checker import kss_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              item_restart,
  input logic              res_valid,
  input logic              res_ready,
  input logic [DATA_W-1:0] res_est0,
  input logic [DATA_W-1:0] res_est1,
  input logic              res_sat
);

  // A waiting result stays offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result valid dropped while stalled");

  // A stalled result keeps its payload.
  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_est0) && $stable(res_est1) && $stable(res_sat))
    else $error("result payload changed while stalled");

  // The block works on one transaction at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item accepted while the previous one is still in progress");

  // A restart to an empty output goes via pend into an unsaturated result.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_restart && !res_valid |=> ##1 res_valid && !res_sat)
    else $error("restart result missing or flagged as saturated");

endmodule

bind steady_state_kalman_step_top kss_checker u_kss_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .item_restart (item.restart),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_est0     (result.estimate_0),
  .res_est1     (result.estimate_1),
  .res_sat      (result.saturated)
);
